/* hdl/text_console_char_writer_unit_defines.svh */
// ----------------------------------------------------------------------------
// text_console_char_writer_unit_defines
// Assertion helpers shared by the RTL files. Each expects clk_i and rst_ni in scope.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CHAR_WRITER_UNIT_DEFINES_SVH
`define TEXT_CONSOLE_CHAR_WRITER_UNIT_DEFINES_SVH

// Property checked on every rising clock edge outside reset.
`define TCCW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the next.
`define TCCW_ASSERT_NEXT(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/tccw_pkg.sv */
// ----------------------------------------------------------------------------
// tccw_pkg
// Types, codes and constants of the text console character writer.
// ----------------------------------------------------------------------------
`default_nettype none

package tccw_pkg;

  localparam int unsigned MaxColsDef = 80;
  localparam int unsigned MaxRowsDef = 50;

  localparam int unsigned RowW     = 6;
  localparam int unsigned ColW     = 7;
  localparam int unsigned LinW     = 12;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned QueueDepth = 2;

  localparam logic [2*ByteW-1:0] ResetCell    = 16'h0720;
  localparam logic [ByteW-1:0]   ChNewline    = 8'd10;
  localparam logic [ByteW-1:0]   ChReturn     = 8'd13;
  localparam logic [ByteW-1:0]   ChBackspace  = 8'd8;
  localparam logic [ByteW-1:0]   ChTab        = 8'd9;
  localparam logic [ByteW-1:0]   ChSpace      = 8'h20;
  localparam logic [ByteW-1:0]   ReadMissAttr = 8'h07;
  localparam logic [ColW:0]      TabStep      = (ColW+1)'(8);
  localparam logic [ColW:0]      TabMask      = ~((ColW+1)'(7));

  typedef enum logic [2:0] {
    OP_PRINT,
    OP_NEWLINE,
    OP_RETURN,
    OP_BACKSPACE,
    OP_TAB,
    OP_READ
  } op_e;

  typedef enum logic [2:0] {
    REG_SCREEN_COLS,
    REG_SCREEN_ROWS,
    REG_VIEW_ENABLE,
    REG_VIEW_TOP,
    REG_VIEW_LEFT,
    REG_VIEW_HEIGHT,
    REG_VIEW_WIDTH,
    REG_TEXT_ATTR
  } reg_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_WRITE,
    S_RD_ADDR,
    S_RD_WAIT,
    S_SC_INIT,
    S_SC_RD,
    S_SC_WR,
    S_SC_BLANK,
    S_OUT
  } back_state_e;

  typedef struct packed {
    logic             kind;
    logic [ByteW-1:0] char_code;
    logic [RowW-1:0]  read_row;
    logic [ColW-1:0]  read_col;
  } in_item_t;

  typedef struct packed {
    logic [RowW-1:0]  cur_row;
    logic [ColW-1:0]  cur_col;
    logic [LinW-1:0]  cur_linear;
    logic             did_scroll;
    logic [ByteW-1:0] cell_char;
    logic [ByteW-1:0] cell_attr;
  } out_item_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] reg_index;
    logic [ByteW-1:0]   wdata;
  } cfg_item_t;

  typedef struct packed {
    op_e              op;
    logic [ByteW-1:0] char_code;
    logic [RowW-1:0]  read_row;
    logic [ColW-1:0]  read_col;
  } cmd_t;

  typedef struct packed {
    logic [ColW-1:0]  sc;
    logic [RowW-1:0]  sr;
    logic [RowW-1:0]  top;
    logic [ColW-1:0]  left;
    logic [RowW-1:0]  h;
    logic [ColW-1:0]  w;
    logic [RowW-1:0]  bottom;
    logic [ColW-1:0]  right;
    logic [ByteW-1:0] attr;
  } geom_t;

  typedef struct packed {
    logic init_done;
  } back_status_t;

endpackage

`default_nettype wire

/* hdl/tccw_stream_if.sv */
// ----------------------------------------------------------------------------
// tccw_stream_if
// Valid/ready channel carrying one payload of type T per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface tccw_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* hdl/tccw_front.sv */
// ----------------------------------------------------------------------------
// tccw_front
// Accepts input transactions and classifies them into commands.
// ----------------------------------------------------------------------------
`default_nettype none

module tccw_front (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  tccw_stream_if.sink                 in_i,
  input  wire tccw_pkg::back_status_t status_i,
  input  wire logic                   q_full_i,
  output      logic                   push_o,
  output      tccw_pkg::cmd_t         cmd_o
);

  logic           valid_q;
  tccw_pkg::cmd_t cmd_q, cmd_d;
  logic           accept;

  always_comb begin
    cmd_d.char_code = in_i.data.char_code;
    cmd_d.read_row  = in_i.data.read_row;
    cmd_d.read_col  = in_i.data.read_col;
    if (in_i.data.kind) begin
      cmd_d.op = tccw_pkg::OP_READ;
    end else begin
      unique case (in_i.data.char_code)
        tccw_pkg::ChNewline:   cmd_d.op = tccw_pkg::OP_NEWLINE;
        tccw_pkg::ChReturn:    cmd_d.op = tccw_pkg::OP_RETURN;
        tccw_pkg::ChBackspace: cmd_d.op = tccw_pkg::OP_BACKSPACE;
        tccw_pkg::ChTab:       cmd_d.op = tccw_pkg::OP_TAB;
        default:               cmd_d.op = tccw_pkg::OP_PRINT;
      endcase
    end
  end

  assign push_o     = valid_q && !q_full_i;
  assign in_i.ready = status_i.init_done && (!valid_q || !q_full_i);
  assign accept     = in_i.valid && in_i.ready;
  assign cmd_o      = cmd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (push_o) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_d;
    end
  end

endmodule

`default_nettype wire

/* hdl/tccw_cmd_queue.sv */
// ----------------------------------------------------------------------------
// tccw_cmd_queue
// Short command FIFO between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

`include "text_console_char_writer_unit_defines.svh"

module tccw_cmd_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire tccw_pkg::cmd_t cmd_i,
  input  wire logic           pop_i,
  output      tccw_pkg::cmd_t cmd_o,
  output      logic           full_o,
  output      logic           empty_o
);

  localparam int unsigned PtrW = (tccw_pkg::QueueDepth > 1) ?
                                 $clog2(tccw_pkg::QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(tccw_pkg::QueueDepth + 1);

  tccw_pkg::cmd_t        slot_q [tccw_pkg::QueueDepth];
  logic [PtrW-1:0]       wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]       count_q;

  assign full_o  = (count_q == CntW'(tccw_pkg::QueueDepth));
  assign empty_o = (count_q == '0);
  assign cmd_o   = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(tccw_pkg::QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(tccw_pkg::QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

  `TCCW_ASSERT(a_no_overflow, !(push_i && full_o), "push into full command queue")
  `TCCW_ASSERT(a_no_underflow, !(pop_i && empty_o), "pop from empty command queue")
  `TCCW_ASSERT_NEXT(a_count_track, push_i && !pop_i, count_q == $past(count_q) + 1'b1,
    "queue fill count did not follow a push")

endmodule

`default_nettype wire

/* hdl/tccw_back.sv */
// ----------------------------------------------------------------------------
// tccw_back
// Executes commands on the cell memory: writes, readback and scrolling.
// ----------------------------------------------------------------------------
`default_nettype none

`include "text_console_char_writer_unit_defines.svh"

module tccw_back #(
  parameter int unsigned MAX_COLS = tccw_pkg::MaxColsDef,
  parameter int unsigned MAX_ROWS = tccw_pkg::MaxRowsDef
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire tccw_pkg::geom_t        geom_i,
  input  wire logic                   q_empty_i,
  input  wire tccw_pkg::cmd_t         q_cmd_i,
  output      logic                   pop_o,
  output      tccw_pkg::back_status_t status_o,
  tccw_stream_if.source               out_o
);

  localparam int unsigned NCells = MAX_COLS * MAX_ROWS;
  localparam int unsigned AW     = $clog2(NCells);
  localparam int unsigned PW     = tccw_pkg::RowW + tccw_pkg::ColW;
  localparam int unsigned SW     = (AW > PW + 1) ? AW : PW + 1;
  localparam int unsigned RowW   = tccw_pkg::RowW;
  localparam int unsigned ColW   = tccw_pkg::ColW;
  localparam int unsigned ByteW  = tccw_pkg::ByteW;

  tccw_pkg::back_state_e state_q, state_d;
  tccw_pkg::cmd_t        cmd_q;
  tccw_pkg::out_item_t   out_q;
  logic                  out_valid_q;

  logic [RowW-1:0]    cur_r_q, wr_row_q, r_q;
  logic [ColW-1:0]    cur_c_q, wr_col_q, c_q;
  logic               wr_en_q, scrolled_q;
  logic [2*ByteW-1:0] wr_data_q, rdata_q;
  logic [ByteW-1:0]   rc_q, ra_q;
  logic [AW-1:0]      row_base_q, clr_q;

  logic [2*ByteW-1:0] mem [NCells];

  // shared address multiplier
  logic [RowW-1:0] mul_row;
  logic [ColW-1:0] mul_col;
  logic [PW-1:0]   mul_prod;
  logic [SW-1:0]   mul_sum;

  // memory port
  logic               mem_we;
  logic [AW-1:0]      mem_addr;
  logic [2*ByteW-1:0] mem_wdata;

  // command execution
  logic [RowW-1:0]    cr, nr;
  logic [ColW-1:0]    cc, nc, wcol;
  logic [ColW:0]      tab_t, inc_t;
  logic               wen;
  logic [2*ByteW-1:0] wdata;
  logic               rd_in_range, out_load, row_last, col_last;
  logic [2*ByteW-1:0] blank;

  assign blank    = {geom_i.attr, tccw_pkg::ChSpace};
  assign mul_prod = PW'(mul_row) * PW'(geom_i.sc);
  assign mul_sum  = SW'(mul_prod) + SW'(mul_col);
  assign col_last = (c_q == geom_i.w - 1'b1);
  assign row_last = (r_q == geom_i.h - RowW'(2));
  assign out_load = (state_q == tccw_pkg::S_OUT) && (!out_valid_q || out_o.ready);
  assign rd_in_range = (cmd_q.read_row < geom_i.sr) && (cmd_q.read_col < geom_i.sc);

  assign status_o.init_done = (state_q != tccw_pkg::S_CLEAR);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // clamp cursor into the region, then apply the command
  always_comb begin
    cr = cur_r_q;
    if (cur_r_q < geom_i.top) begin
      cr = geom_i.top;
    end else if (cur_r_q > geom_i.bottom - 1'b1) begin
      cr = geom_i.bottom - 1'b1;
    end
    cc = cur_c_q;
    if (cur_c_q < geom_i.left) begin
      cc = geom_i.left;
    end else if (cur_c_q > geom_i.right - 1'b1) begin
      cc = geom_i.right - 1'b1;
    end
    tab_t = ((({1'b0, cc} - {1'b0, geom_i.left}) + tccw_pkg::TabStep) & tccw_pkg::TabMask)
            + {1'b0, geom_i.left};
    inc_t = {1'b0, cc} + 1'b1;
    nr    = cr;
    nc    = cc;
    wcol  = cc;
    wen   = 1'b0;
    wdata = blank;
    unique case (cmd_q.op)
      tccw_pkg::OP_NEWLINE: begin
        nc = geom_i.left;
        nr = cr + 1'b1;
      end
      tccw_pkg::OP_RETURN: begin
        nc = geom_i.left;
      end
      tccw_pkg::OP_BACKSPACE: begin
        wcol = (cc > geom_i.left) ? cc - 1'b1 : cc;
        nc   = wcol;
        wen  = 1'b1;
      end
      tccw_pkg::OP_TAB: begin
        if (tab_t >= {1'b0, geom_i.right}) begin
          nc = geom_i.left;
          nr = cr + 1'b1;
        end else begin
          nc = tab_t[ColW-1:0];
        end
      end
      tccw_pkg::OP_PRINT: begin
        wen   = 1'b1;
        wdata = {geom_i.attr, cmd_q.char_code};
        if (inc_t >= {1'b0, geom_i.right}) begin
          nc = geom_i.left;
          nr = cr + 1'b1;
        end else begin
          nc = inc_t[ColW-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tccw_pkg::S_CLEAR:   if (clr_q == AW'(NCells - 1)) state_d = tccw_pkg::S_IDLE;
      tccw_pkg::S_IDLE:    if (!q_empty_i) state_d = tccw_pkg::S_EXEC;
      tccw_pkg::S_EXEC: begin
        if (cmd_q.op == tccw_pkg::OP_READ) begin
          state_d = rd_in_range ? tccw_pkg::S_RD_ADDR : tccw_pkg::S_OUT;
        end else begin
          state_d = tccw_pkg::S_WRITE;
        end
      end
      tccw_pkg::S_WRITE: begin
        state_d = (cur_r_q >= geom_i.bottom) ? tccw_pkg::S_SC_INIT : tccw_pkg::S_OUT;
      end
      tccw_pkg::S_RD_ADDR: state_d = tccw_pkg::S_RD_WAIT;
      tccw_pkg::S_RD_WAIT: state_d = tccw_pkg::S_OUT;
      tccw_pkg::S_SC_INIT: begin
        state_d = (geom_i.h > RowW'(1)) ? tccw_pkg::S_SC_RD : tccw_pkg::S_SC_BLANK;
      end
      tccw_pkg::S_SC_RD:   state_d = tccw_pkg::S_SC_WR;
      tccw_pkg::S_SC_WR: begin
        state_d = (col_last && row_last) ? tccw_pkg::S_SC_BLANK : tccw_pkg::S_SC_RD;
      end
      tccw_pkg::S_SC_BLANK: if (col_last) state_d = tccw_pkg::S_OUT;
      tccw_pkg::S_OUT:     if (out_load) state_d = tccw_pkg::S_IDLE;
      default:             state_d = tccw_pkg::S_IDLE;
    endcase
  end

  // outputs: queue pop, multiplier operands, memory port
  always_comb begin
    pop_o     = 1'b0;
    mul_row   = cur_r_q;
    mul_col   = cur_c_q;
    mem_we    = 1'b0;
    mem_addr  = mul_sum[AW-1:0];
    mem_wdata = blank;
    unique case (state_q)
      tccw_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_q;
        mem_wdata = tccw_pkg::ResetCell;
      end
      tccw_pkg::S_IDLE: pop_o = !q_empty_i;
      tccw_pkg::S_WRITE: begin
        mul_row   = wr_row_q;
        mul_col   = wr_col_q;
        mem_we    = wr_en_q;
        mem_wdata = wr_data_q;
      end
      tccw_pkg::S_RD_ADDR: begin
        mul_row = cmd_q.read_row;
        mul_col = cmd_q.read_col;
      end
      tccw_pkg::S_SC_INIT: begin
        mul_row = geom_i.top;
        mul_col = geom_i.left;
      end
      tccw_pkg::S_SC_RD: begin
        mem_addr = row_base_q + AW'(geom_i.sc) + AW'(c_q);
      end
      tccw_pkg::S_SC_WR: begin
        mem_we    = 1'b1;
        mem_addr  = row_base_q + AW'(c_q);
        mem_wdata = rdata_q;
      end
      tccw_pkg::S_SC_BLANK: begin
        mem_we   = 1'b1;
        mem_addr = row_base_q + AW'(c_q);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rdata_q <= mem[mem_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tccw_pkg::S_CLEAR;
      clr_q       <= '0;
      cur_r_q     <= '0;
      cur_c_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == tccw_pkg::S_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
      if (state_q == tccw_pkg::S_EXEC && cmd_q.op != tccw_pkg::OP_READ) begin
        cur_r_q <= nr;
        cur_c_q <= nc;
      end else if (state_q == tccw_pkg::S_SC_BLANK && col_last) begin
        cur_r_q <= geom_i.bottom - 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      tccw_pkg::S_IDLE: begin
        if (!q_empty_i) cmd_q <= q_cmd_i;
      end
      tccw_pkg::S_EXEC: begin
        wr_row_q   <= cr;
        wr_col_q   <= wcol;
        wr_en_q    <= wen;
        wr_data_q  <= wdata;
        scrolled_q <= 1'b0;
        if (cmd_q.op == tccw_pkg::OP_READ) begin
          rc_q <= tccw_pkg::ChSpace;
          ra_q <= tccw_pkg::ReadMissAttr;
        end else begin
          rc_q <= '0;
          ra_q <= '0;
        end
      end
      tccw_pkg::S_RD_WAIT: begin
        rc_q <= rdata_q[ByteW-1:0];
        ra_q <= rdata_q[2*ByteW-1:ByteW];
      end
      tccw_pkg::S_SC_INIT: begin
        row_base_q <= mul_sum[AW-1:0];
        c_q        <= '0;
        r_q        <= '0;
      end
      tccw_pkg::S_SC_WR: begin
        if (col_last) begin
          c_q        <= '0;
          r_q        <= r_q + 1'b1;
          row_base_q <= row_base_q + AW'(geom_i.sc);
        end else begin
          c_q <= c_q + 1'b1;
        end
      end
      tccw_pkg::S_SC_BLANK: begin
        c_q <= c_q + 1'b1;
        if (col_last) scrolled_q <= 1'b1;
      end
      tccw_pkg::S_OUT: begin
        if (out_load) begin
          out_q.cur_row    <= cur_r_q;
          out_q.cur_col    <= cur_c_q;
          out_q.cur_linear <= mul_sum[tccw_pkg::LinW-1:0];
          out_q.did_scroll <= scrolled_q;
          out_q.cell_char  <= rc_q;
          out_q.cell_attr  <= ra_q;
        end
      end
      default: begin
      end
    endcase
  end

  `TCCW_ASSERT(a_no_pop_in_clear, !(state_q == tccw_pkg::S_CLEAR && pop_o),
    "command taken during clearing pass")
  `TCCW_ASSERT(a_cursor_in_region,
    !(out_load && cmd_q.op != tccw_pkg::OP_READ) || (cur_r_q < geom_i.bottom),
    "cursor row left the region after a write")
  `TCCW_ASSERT_NEXT(a_copy_order, state_q == tccw_pkg::S_SC_RD,
    state_q == tccw_pkg::S_SC_WR, "scroll copy write did not follow its read")
  `TCCW_ASSERT_NEXT(a_scroll_flag, state_q == tccw_pkg::S_SC_BLANK && col_last,
    scrolled_q && state_q == tccw_pkg::S_OUT, "scroll did not end in a flagged result")

endmodule

`default_nettype wire

/* hdl/text_console_char_writer_unit.sv */
// ----------------------------------------------------------------------------
// text_console_char_writer_unit
// Text console character writer: cursor handling, cell store and scrolling.
// ----------------------------------------------------------------------------
// Every transaction passes through the front register. In the back end a
// write then passes through take, execute, cell write and result; a read
// through take, execute, address, data and result, or take, execute and
// result when it falls outside the screen. A write that scrolls goes on with
// a scroll set-up, a read and a write for every moved cell of the region,
// since the cell memory is single-port, and a blank write for each cell of
// the bottom row. After reset a clearing pass writes blanks to all
// MAX_COLS*MAX_ROWS cells, one per cycle, with the input not ready;
// configuration writes are taken at any time.
`default_nettype none

module text_console_char_writer_unit #(
  parameter int unsigned MAX_COLS = tccw_pkg::MaxColsDef,
  parameter int unsigned MAX_ROWS = tccw_pkg::MaxRowsDef
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  tccw_stream_if.sink   in_i,
  tccw_stream_if.source out_o,
  tccw_stream_if.sink   cfg_i
);

  localparam int unsigned RowW = tccw_pkg::RowW;
  localparam int unsigned ColW = tccw_pkg::ColW;

  logic [ColW-1:0]  cols_q, vleft_q, vwidth_q;
  logic [RowW-1:0]  rows_q, vtop_q, vheight_q;
  logic             ven_q;
  logic [tccw_pkg::ByteW-1:0] attr_q;

  tccw_pkg::geom_t        geom_d, geom_q;
  tccw_pkg::back_status_t status;
  tccw_pkg::cmd_t         f_cmd, q_cmd;
  logic                   push, pop, q_full, q_empty;
  logic [RowW-1:0]        room_r;
  logic [ColW-1:0]        room_c;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q    <= ColW'(80);
      rows_q    <= RowW'(25);
      ven_q     <= 1'b0;
      vtop_q    <= '0;
      vleft_q   <= '0;
      vheight_q <= RowW'(25);
      vwidth_q  <= ColW'(80);
      attr_q    <= tccw_pkg::ReadMissAttr;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.data.reg_index)
        tccw_pkg::CfgIdxW'(tccw_pkg::REG_SCREEN_COLS): cols_q    <= cfg_i.data.wdata[ColW-1:0];
        tccw_pkg::CfgIdxW'(tccw_pkg::REG_SCREEN_ROWS): rows_q    <= cfg_i.data.wdata[RowW-1:0];
        tccw_pkg::CfgIdxW'(tccw_pkg::REG_VIEW_ENABLE): ven_q     <= cfg_i.data.wdata[0];
        tccw_pkg::CfgIdxW'(tccw_pkg::REG_VIEW_TOP):    vtop_q    <= cfg_i.data.wdata[RowW-1:0];
        tccw_pkg::CfgIdxW'(tccw_pkg::REG_VIEW_LEFT):   vleft_q   <= cfg_i.data.wdata[ColW-1:0];
        tccw_pkg::CfgIdxW'(tccw_pkg::REG_VIEW_HEIGHT): vheight_q <= cfg_i.data.wdata[RowW-1:0];
        tccw_pkg::CfgIdxW'(tccw_pkg::REG_VIEW_WIDTH):  vwidth_q  <= cfg_i.data.wdata[ColW-1:0];
        tccw_pkg::CfgIdxW'(tccw_pkg::REG_TEXT_ATTR):   attr_q    <= cfg_i.data.wdata;
        default: begin
        end
      endcase
    end
  end

  // saturate screen size and viewport box into the usable range
  always_comb begin
    geom_d.attr = attr_q;
    if (cols_q == '0) begin
      geom_d.sc = ColW'(1);
    end else if (int'(cols_q) > MAX_COLS) begin
      geom_d.sc = ColW'(MAX_COLS);
    end else begin
      geom_d.sc = cols_q;
    end
    if (rows_q == '0) begin
      geom_d.sr = RowW'(1);
    end else if (int'(rows_q) > MAX_ROWS) begin
      geom_d.sr = RowW'(MAX_ROWS);
    end else begin
      geom_d.sr = rows_q;
    end
    geom_d.top  = '0;
    geom_d.left = '0;
    geom_d.h    = geom_d.sr;
    geom_d.w    = geom_d.sc;
    room_r      = geom_d.sr;
    room_c      = geom_d.sc;
    if (ven_q) begin
      geom_d.top  = (vtop_q > geom_d.sr - 1'b1) ? geom_d.sr - 1'b1 : vtop_q;
      geom_d.left = (vleft_q > geom_d.sc - 1'b1) ? geom_d.sc - 1'b1 : vleft_q;
      room_r      = geom_d.sr - geom_d.top;
      room_c      = geom_d.sc - geom_d.left;
      if (vheight_q == '0) begin
        geom_d.h = RowW'(1);
      end else begin
        geom_d.h = (vheight_q > room_r) ? room_r : vheight_q;
      end
      if (vwidth_q == '0) begin
        geom_d.w = ColW'(1);
      end else begin
        geom_d.w = (vwidth_q > room_c) ? room_c : vwidth_q;
      end
    end
    geom_d.bottom = geom_d.top + geom_d.h;
    geom_d.right  = geom_d.left + geom_d.w;
  end

  always_ff @(posedge clk_i) begin
    geom_q <= geom_d;
  end

  tccw_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .status_i (status),
    .q_full_i (q_full),
    .push_o   (push),
    .cmd_o    (f_cmd)
  );

  tccw_cmd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (f_cmd),
    .pop_i   (pop),
    .cmd_o   (q_cmd),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  tccw_back #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .geom_i    (geom_q),
    .q_empty_i (q_empty),
    .q_cmd_i   (q_cmd),
    .pop_o     (pop),
    .status_o  (status),
    .out_o     (out_o)
  );

endmodule

`default_nettype wire
